### hdl/rsps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rank sorted parent set package
// Shared types and constants for the controller, datapath and top level.
// ----------------------------------------------------------------------------
package rsps_pkg;

  localparam int DEF_ENTRIES = 8;
  localparam int KEY_W       = 64;
  localparam int RANK_W      = 16;
  localparam int ID_W        = 16;
  localparam int METRIC_W    = 64;
  localparam int COUNT_W     = 4;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_INSERT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic remove;
    logic insert;
  } cmd_t;

  typedef struct packed {
    logic lookup;
    logic hit;
    logic reject;
  } sts_t;

endpackage : rsps_pkg
`default_nettype wire

### hdl/rank_sorted_parent_set.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rank sorted parent set
// Table of neighbor parents kept in ascending rank order, with keyed
// update and lookup requests and one response per request.
//
//   Channel  Handshake              Payload
//   req      req_valid/req_ready    action, parent_key, parent_rank,
//                                   parent_id, parent_metric
//   rsp      rsp_valid/rsp_ready    found, looked_rank, looked_metric,
//                                   looked_id, best_rank, entry_count, rejected
//
// A lookup or a rejected update presents its response after the key match
// state, an applied update after key match and removal, then ordered
// insertion. One request is in flight at a time; the next is taken the cycle
// after the response is accepted. Reset empties the table at once.
// A stalled response holds the block in its response state.
// ----------------------------------------------------------------------------
module rank_sorted_parent_set #(
  parameter int ENTRIES = rsps_pkg::DEF_ENTRIES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire logic                            action,
  input  wire logic [rsps_pkg::KEY_W-1:0]      parent_key,
  input  wire logic [rsps_pkg::RANK_W-1:0]     parent_rank,
  input  wire logic [rsps_pkg::ID_W-1:0]       parent_id,
  input  wire logic [rsps_pkg::METRIC_W-1:0]   parent_metric,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output logic                                 found,
  output logic [rsps_pkg::RANK_W-1:0]          looked_rank,
  output logic [rsps_pkg::METRIC_W-1:0]        looked_metric,
  output logic [rsps_pkg::ID_W-1:0]            looked_id,
  output logic [rsps_pkg::RANK_W-1:0]          best_rank,
  output logic [rsps_pkg::COUNT_W-1:0]         entry_count,
  output logic                                 rejected
);
  import rsps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rsps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsps_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (action),
    .parent_key    (parent_key),
    .parent_rank   (parent_rank),
    .parent_id     (parent_id),
    .parent_metric (parent_metric),
    .found         (found),
    .looked_rank   (looked_rank),
    .looked_metric (looked_metric),
    .looked_id     (looked_id),
    .best_rank     (best_rank),
    .entry_count   (entry_count),
    .rejected      (rejected)
  );

endmodule : rank_sorted_parent_set
`default_nettype wire

### hdl/rsps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rank sorted parent set controller
// Sequences accept, key match, ordered insert (applied updates only) and response for each request.
// ----------------------------------------------------------------------------
module rsps_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  input  wire rsps_pkg::sts_t sts,
  output rsps_pkg::cmd_t     cmd
);
  import rsps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_MATCH;
      end
      ST_MATCH: begin
        if (sts.lookup || sts.reject) state_next = ST_RESP;
        else state_next = ST_INSERT;
      end
      ST_INSERT: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_MATCH: begin
        cmd.match  = 1'b1;
        cmd.remove = !sts.lookup && !sts.reject && sts.hit;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
      end
      ST_RESP: begin
        rsp_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule : rsps_ctrl
`default_nettype wire

### hdl/rsps_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rank sorted parent set datapath
// A chain of entry cells kept in rank order, with parallel key and rank
// compare, one-step removal and one-step ordered insertion.
// ----------------------------------------------------------------------------
module rsps_dp #(
  parameter int ENTRIES = rsps_pkg::DEF_ENTRIES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rsps_pkg::cmd_t                  cmd,
  output rsps_pkg::sts_t                       sts,
  input  wire logic                            action,
  input  wire logic [rsps_pkg::KEY_W-1:0]      parent_key,
  input  wire logic [rsps_pkg::RANK_W-1:0]     parent_rank,
  input  wire logic [rsps_pkg::ID_W-1:0]       parent_id,
  input  wire logic [rsps_pkg::METRIC_W-1:0]   parent_metric,
  output logic                                 found,
  output logic [rsps_pkg::RANK_W-1:0]          looked_rank,
  output logic [rsps_pkg::METRIC_W-1:0]        looked_metric,
  output logic [rsps_pkg::ID_W-1:0]            looked_id,
  output logic [rsps_pkg::RANK_W-1:0]          best_rank,
  output logic [rsps_pkg::COUNT_W-1:0]         entry_count,
  output logic                                 rejected
);
  import rsps_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [KEY_W-1:0]    cell_key    [ENTRIES];
  logic [RANK_W-1:0]   cell_rank   [ENTRIES];
  logic [ID_W-1:0]     cell_id     [ENTRIES];
  logic [METRIC_W-1:0] cell_metric [ENTRIES];
  logic [CW-1:0]       count;

  logic                req_action;
  logic [KEY_W-1:0]    req_key;
  logic [RANK_W-1:0]   req_rank;
  logic [ID_W-1:0]     req_id;
  logic [METRIC_W-1:0] req_metric;

  logic [ENTRIES-1:0]  match_vec;
  logic [ENTRIES-1:0]  place_vec;
  logic [IW-1:0]       hit_idx;
  logic                hit;
  logic                full;
  logic [RANK_W-1:0]   sel_rank;
  logic [ID_W-1:0]     sel_id;
  logic [METRIC_W-1:0] sel_metric;
  logic [6:0]          count_ext;

  always_comb begin
    match_vec  = '0;
    place_vec  = '0;
    hit_idx    = '0;
    sel_rank   = '0;
    sel_id     = '0;
    sel_metric = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = (CW'(i) < count) && (cell_key[i] == req_key);
      place_vec[i] = (CW'(i) == count) ||
                     ((CW'(i) < count) && (cell_rank[i] > req_rank));
      if (match_vec[i]) begin
        hit_idx    = hit_idx | IW'(i);
        sel_rank   = sel_rank | cell_rank[i];
        sel_id     = sel_id | cell_id[i];
        sel_metric = sel_metric | cell_metric[i];
      end
    end
    hit  = |match_vec;
    full = (count == CW'(ENTRIES));
  end

  assign sts.lookup = (req_action == ACT_LOOKUP);
  assign sts.hit    = hit;
  assign sts.reject = (req_action == ACT_UPDATE) && !hit && full;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= action;
      req_key    <= parent_key;
      req_rank   <= parent_rank;
      req_id     <= parent_id;
      req_metric <= parent_metric;
    end
    if (cmd.match) begin
      found    <= hit;
      rejected <= sts.reject;
      if (sts.lookup) begin
        looked_rank   <= sel_rank;
        looked_id     <= sel_id;
        looked_metric <= sel_metric;
      end else begin
        looked_rank   <= '0;
        looked_id     <= '0;
        looked_metric <= '0;
      end
    end
    if (cmd.remove) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (IW'(i) >= hit_idx) begin
          cell_key[i]    <= cell_key[i+1];
          cell_rank[i]   <= cell_rank[i+1];
          cell_id[i]     <= cell_id[i+1];
          cell_metric[i] <= cell_metric[i+1];
        end
      end
    end
    if (cmd.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (place_vec[i]) begin
          if (i == 0 || !place_vec[(i > 0) ? i - 1 : 0]) begin
            cell_key[i]    <= req_key;
            cell_rank[i]   <= req_rank;
            cell_id[i]     <= req_id;
            cell_metric[i] <= req_metric;
          end else begin
            cell_key[i]    <= cell_key[(i > 0) ? i - 1 : 0];
            cell_rank[i]   <= cell_rank[(i > 0) ? i - 1 : 0];
            cell_id[i]     <= cell_id[(i > 0) ? i - 1 : 0];
            cell_metric[i] <= cell_metric[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.remove) begin
      count <= count - CW'(1);
    end else if (cmd.insert) begin
      count <= count + CW'(1);
    end
  end

  assign best_rank   = (count != '0) ? cell_rank[0] : '0;
  assign count_ext   = 7'(count);
  assign entry_count = count_ext[COUNT_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("entry count exceeds table size");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> (count < CW'(ENTRIES)))
    else $error("insert issued on a full table");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the table by one");

  a_remove_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |-> (hit && count != '0))
    else $error("removal without a matching entry");

endmodule : rsps_dp
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank sorted parent set testbench
// Sends update and lookup requests with random gaps and response stalls,
// predicts each response from a private copy of the sorted parent table,
// and compares every response field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import rsps_pkg::*;

  localparam int ENTRIES     = DEF_ENTRIES;
  localparam int SW          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct {
    logic                found;
    logic [RANK_W-1:0]   looked_rank;
    logic [METRIC_W-1:0] looked_metric;
    logic [ID_W-1:0]     looked_id;
    logic [RANK_W-1:0]   best_rank;
    logic [COUNT_W-1:0]  entry_count;
    logic                rejected;
  } parent_rsp_t;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_ready;
  logic                action;
  logic [KEY_W-1:0]    parent_key;
  logic [RANK_W-1:0]   parent_rank;
  logic [ID_W-1:0]     parent_id;
  logic [METRIC_W-1:0] parent_metric;
  logic                rsp_valid;
  logic                rsp_ready;
  logic                found;
  logic [RANK_W-1:0]   looked_rank;
  logic [METRIC_W-1:0] looked_metric;
  logic [ID_W-1:0]     looked_id;
  logic [RANK_W-1:0]   best_rank;
  logic [COUNT_W-1:0]  entry_count;
  logic                rejected;

  logic [KEY_W-1:0]    set_keys    [ENTRIES];
  logic [RANK_W-1:0]   set_ranks   [ENTRIES];
  logic [ID_W-1:0]     set_ids     [ENTRIES];
  logic [METRIC_W-1:0] set_metrics [ENTRIES];
  int                  set_cnt;
  logic [RANK_W-1:0]   set_head;

  parent_rsp_t rsp_due_q [$];
  int          mismatch_cnt;
  int          cycle_cnt;
  bit          steady_flow;

  rank_sorted_parent_set #(.ENTRIES(ENTRIES)) u_top (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .action        (action),
    .parent_key    (parent_key),
    .parent_rank   (parent_rank),
    .parent_id     (parent_id),
    .parent_metric (parent_metric),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .found         (found),
    .looked_rank   (looked_rank),
    .looked_metric (looked_metric),
    .looked_id     (looked_id),
    .best_rank     (best_rank),
    .entry_count   (entry_count),
    .rejected      (rejected)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Applies one request to the private parent table and returns its response.
  function automatic parent_rsp_t apply_parent_req(input logic act,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [RANK_W-1:0] rank,
                                                   input logic [ID_W-1:0] id,
                                                   input logic [METRIC_W-1:0] metric);
    parent_rsp_t r;
    int          hit;
    int          pos;
    int          i;
    hit = -1;
    for (i = 0; i < set_cnt; i++) begin
      if (hit < 0 && set_keys[i] == key) hit = i;
    end
    r.found         = (hit >= 0);
    r.looked_rank   = '0;
    r.looked_metric = '0;
    r.looked_id     = '0;
    r.rejected      = 1'b0;
    if (act == ACT_LOOKUP) begin
      if (hit >= 0) begin
        r.looked_rank   = set_ranks[hit];
        r.looked_metric = set_metrics[hit];
        r.looked_id     = set_ids[hit];
      end
    end else if (hit < 0 && set_cnt >= ENTRIES) begin
      r.rejected = 1'b1;
    end else begin
      if (hit >= 0) begin
        for (i = hit; i + 1 < set_cnt; i++) begin
          set_keys[i]    = set_keys[i+1];
          set_ranks[i]   = set_ranks[i+1];
          set_ids[i]     = set_ids[i+1];
          set_metrics[i] = set_metrics[i+1];
        end
        set_cnt--;
      end
      pos = set_cnt;
      for (i = set_cnt - 1; i >= 0; i--) begin
        if (set_ranks[i] > rank) pos = i;
      end
      for (i = set_cnt; i > pos; i--) begin
        set_keys[i]    = set_keys[i-1];
        set_ranks[i]   = set_ranks[i-1];
        set_ids[i]     = set_ids[i-1];
        set_metrics[i] = set_metrics[i-1];
      end
      set_keys[pos]    = key;
      set_ranks[pos]   = rank;
      set_ids[pos]     = id;
      set_metrics[pos] = metric;
      set_cnt++;
      set_head = set_ranks[0];
    end
    r.best_rank   = (set_cnt > 0) ? set_head : '0;
    r.entry_count = set_cnt[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void add_due(input parent_rsp_t due);
    rsp_due_q = {rsp_due_q, due};
  endfunction

  // Must be called right after a rising edge.
  task automatic send_req(input logic act, input logic [KEY_W-1:0] key,
                          input logic [RANK_W-1:0] rank, input logic [ID_W-1:0] id,
                          input logic [METRIC_W-1:0] metric);
    int gap;
    req_valid     <= 1'b1;
    action        <= act;
    parent_key    <= key;
    parent_rank   <= rank;
    parent_id     <= id;
    parent_metric <= metric;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    add_due(apply_parent_req(act, key, rank, id, metric));
    gap = pick_idle();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_empty_table();
    send_req(ACT_LOOKUP, '0, '0, '0, '0);
    send_req(ACT_LOOKUP, '1, '1, '1, '1);
  endtask

  task automatic test_ordered_insert();
    send_req(ACT_UPDATE, 64'h0123_4567_89ab_cdef, 16'd100, 16'h1111, 64'h1);
    send_req(ACT_UPDATE, 64'hfedc_ba98_7654_3210, 16'd50, 16'h2222, 64'h2);
    send_req(ACT_UPDATE, 64'h5555_aaaa_5555_aaaa, 16'd100, 16'h3333, 64'h3);
    send_req(ACT_UPDATE, '0, 16'h0000, 16'h0000, 64'h0);
    send_req(ACT_UPDATE, '1, 16'hffff, 16'hffff, '1);
    send_req(ACT_LOOKUP, '0, '1, '1, '1);
    send_req(ACT_LOOKUP, '1, '0, '0, '0);
    send_req(ACT_LOOKUP, 64'h5555_aaaa_5555_aaaa, '0, '0, '0);
  endtask

  task automatic test_replace_known();
    send_req(ACT_UPDATE, '0, 16'd75, 16'h4444, 64'hdead_beef_0000_0001);
    send_req(ACT_UPDATE, 64'h0123_4567_89ab_cdef, 16'd50, 16'h5555, 64'h8000_0000_0000_0000);
    send_req(ACT_LOOKUP, 64'h0123_4567_89ab_cdef, '0, '0, '0);
    send_req(ACT_LOOKUP, '0, '0, '0, '0);
  endtask

  task automatic test_full_table();
    send_req(ACT_UPDATE, 64'h1000, 16'd7, 16'h0001, 64'h10);
    send_req(ACT_UPDATE, 64'h2000, 16'd7, 16'h0002, 64'h20);
    send_req(ACT_UPDATE, 64'h3000, 16'd1, 16'h0003, 64'h30);
    send_req(ACT_UPDATE, 64'h4000, 16'd0, 16'h0004, 64'h40);
    send_req(ACT_LOOKUP, 64'h4000, '0, '0, '0);
    send_req(ACT_UPDATE, 64'hfedc_ba98_7654_3210, 16'hffff, 16'h0005, 64'h50);
    send_req(ACT_LOOKUP, 64'hfedc_ba98_7654_3210, '0, '0, '0);
    send_req(ACT_LOOKUP, 64'h2000, '0, '0, '0);
  endtask

  // The table stays full once filled, and most updates reuse stored keys.
  task automatic test_random_traffic(input int n_items);
    int                  k;
    logic                act;
    logic [KEY_W-1:0]    key;
    logic [RANK_W-1:0]   rank;
    logic [SW-1:0]       slot;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      act = ($urandom_range(0, 99) < 35) ? ACT_LOOKUP : ACT_UPDATE;
      if (set_cnt > 0 && $urandom_range(0, 99) < 75) begin
        slot = SW'($urandom_range(0, set_cnt - 1));
        key  = set_keys[slot];
      end else begin
        key = rand64();
      end
      if ($urandom_range(0, 1) == 0)
        rank = RANK_W'($urandom_range(0, 7));
      else
        rank = RANK_W'($urandom_range(0, 16'hffff));
      send_req(act, key, rank, ID_W'($urandom_range(0, 16'hffff)), rand64());
    end
    steady_flow = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin : rsp_check
    parent_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_due_q.size() == 0) begin
        $display("%0t: response with none outstanding, expected none, actual found=%b",
                 $time, found);
        mismatch_cnt++;
      end else begin
        want = rsp_due_q.pop_front();
        check_field("found", 64'(want.found), 64'(found));
        check_field("looked_rank", 64'(want.looked_rank), 64'(looked_rank));
        check_field("looked_metric", want.looked_metric, looked_metric);
        check_field("looked_id", 64'(want.looked_id), 64'(looked_id));
        check_field("best_rank", 64'(want.best_rank), 64'(best_rank));
        check_field("entry_count", 64'(want.entry_count), 64'(entry_count));
        check_field("rejected", 64'(want.rejected), 64'(rejected));
      end
    end
  end

  initial begin : rsp_stall
    int stall;
    rsp_ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        stall--;
      end else begin
        rsp_ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall = pick_idle();
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    action        = ACT_UPDATE;
    parent_key    = '0;
    parent_rank   = '0;
    parent_id     = '0;
    parent_metric = '0;
    set_cnt       = 0;
    set_head      = '0;
    mismatch_cnt  = 0;
    steady_flow   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_ordered_insert();
    test_replace_known();
    test_full_table();
    test_random_traffic(400);

    req_valid <= 1'b0;
    while (rsp_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/rsps_pkg.sv
hdl/rsps_ctrl.sv
hdl/rsps_dp.sv
hdl/rank_sorted_parent_set.sv
tb/tb_top.sv
